// ===== design/hid_report_layout_parser_assert.svh =====
`ifndef HID_REPORT_LAYOUT_PARSER_ASSERT_SVH
`define HID_REPORT_LAYOUT_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define HRLP_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define HRLP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/hrlp_pkg.sv =====
package hrlp_pkg;

  // Item prefixes
  localparam logic [7:0] PFX_USAGE_PAGE   = 8'h05;
  localparam logic [7:0] PFX_USAGE        = 8'h09;
  localparam logic [7:0] PFX_USAGE_EXT    = 8'h0a;
  localparam logic [7:0] PFX_REPORT_COUNT = 8'h95;
  localparam logic [7:0] PFX_REPORT_SIZE  = 8'h75;
  localparam logic [7:0] PFX_INPUT        = 8'h81;
  localparam logic [7:0] PFX_OUTPUT       = 8'h91;

  // Size code that means four data bytes
  localparam logic [1:0] SIZE_CODE_LONG = 2'd3;
  localparam logic [2:0] LONG_DATA_BYTES = 3'd4;

  // Usage pages
  localparam logic [7:0] PAGE_DESKTOP  = 8'h01;
  localparam logic [7:0] PAGE_BUTTON   = 8'h09;
  localparam logic [7:0] PAGE_CONSUMER = 8'h0c;

  // Usages
  localparam logic [15:0] USAGE_X      = 16'h0030;
  localparam logic [15:0] USAGE_Y      = 16'h0031;
  localparam logic [15:0] USAGE_WHEEL  = 16'h0038;
  localparam logic [15:0] USAGE_AC_PAN = 16'h0238;

  // Layout slots
  localparam int LAYOUT_FIELDS = 5;
  localparam int L_BUTTON = 0;
  localparam int L_X      = 1;
  localparam int L_Y      = 2;
  localparam int L_WHEEL  = 3;
  localparam int L_PAN    = 4;

  // Item queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PW    = 2;
  localparam int QUEUE_CW    = 3;

  localparam logic [7:0] REPORT_COUNT_RESET = 8'd1;

  // One queued word: an assembled item and/or the end-of-descriptor mark
  typedef struct packed {
    logic        has_item;
    logic [7:0]  prefix;
    logic [15:0] value;
    logic        last;
  } hrlp_entry_t;

  typedef struct packed {
    logic [7:0] button_start;
    logic [7:0] button_length;
    logic [7:0] x_start;
    logic [7:0] x_length;
    logic [7:0] y_start;
    logic [7:0] y_length;
    logic [7:0] wheel_start;
    logic [7:0] wheel_length;
    logic [7:0] pan_start;
    logic [7:0] pan_length;
  } hrlp_layout_t;

  typedef struct packed {
    logic pop;
    logic emit;
  } hrlp_exec_stat_t;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_WALK,
    EX_EMIT
  } hrlp_exec_state_t;

endpackage

// ===== design/hid_report_layout_parser.sv =====
// Path: the last byte's end mark goes through the item queue; the back end walks the usages
//   of any Input items ahead of or with it, then enters EMIT and registers the layout.
// Throughput: 1 byte per cycle into a 4-word item queue while in_stall (queue full) is low;
//   the back end runs 1 item per cycle while idle, but an Input item on Generic Desktop or
//   Consumer walks its n usages one by one (n = clamped usage count, up to USAGE_SLOTS).
// Reset: synchronous, active high rst returns parser, queue and output to empty state.
module hid_report_layout_parser #(
  parameter int USAGE_SLOTS = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] desc_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] button_start,
  output logic [7:0] button_length,
  output logic [7:0] x_start,
  output logic [7:0] x_length,
  output logic [7:0] y_start,
  output logic [7:0] y_length,
  output logic [7:0] wheel_start,
  output logic [7:0] wheel_length,
  output logic [7:0] pan_start,
  output logic [7:0] pan_length
);

  `include "hid_report_layout_parser_assert.svh"

  logic                      q_push;
  logic                      q_pop;
  logic                      q_full;
  logic                      q_empty;
  hrlp_pkg::hrlp_entry_t     q_wdata;
  hrlp_pkg::hrlp_entry_t     q_rdata;
  hrlp_pkg::hrlp_layout_t    out_layout;
  hrlp_pkg::hrlp_exec_stat_t stat;

  hrlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .desc_byte (desc_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  hrlp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  hrlp_exec #(
    .USAGE_SLOTS (USAGE_SLOTS)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_layout (out_layout),
    .stat       (stat)
  );

  // Unpack the result word
  assign button_start  = out_layout.button_start;
  assign button_length = out_layout.button_length;
  assign x_start       = out_layout.x_start;
  assign x_length      = out_layout.x_length;
  assign y_start       = out_layout.y_start;
  assign y_length      = out_layout.y_length;
  assign wheel_start   = out_layout.wheel_start;
  assign wheel_length  = out_layout.wheel_length;
  assign pan_start     = out_layout.pan_start;
  assign pan_length    = out_layout.pan_length;

  `HRLP_CHECK(a_no_push_full, q_full, !q_push, "item pushed into full queue")
  `HRLP_CHECK(a_no_pop_empty, stat.pop, !q_empty, "item popped from empty queue")
  `HRLP_CHECK_NEXT(a_emit_valid, stat.emit, out_valid, "emitted layout not presented")

endmodule

// ===== design/hrlp_front.sv =====
module hrlp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           desc_byte,
  input  logic                 last_byte,
  input  logic                 q_full,
  output logic                 q_push,
  output hrlp_pkg::hrlp_entry_t q_wdata
);

  logic [7:0]  item_prefix;
  logic [2:0]  bytes_left;
  logic [15:0] item_value;
  logic [2:0]  byte_index;

  logic [7:0]  item_prefix_next;
  logic [2:0]  bytes_left_next;
  logic [15:0] item_value_next;
  logic [2:0]  byte_index_next;
  logic        accept;
  logic        complete;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Assemble the current item from prefix and data bytes
  always_comb begin
    item_prefix_next = item_prefix;
    item_value_next  = item_value;
    byte_index_next  = byte_index;
    bytes_left_next  = bytes_left;
    complete         = 1'b0;
    if (bytes_left == 3'd0) begin
      item_prefix_next = desc_byte;
      item_value_next  = 16'd0;
      byte_index_next  = 3'd0;
      bytes_left_next  = (desc_byte[1:0] == hrlp_pkg::SIZE_CODE_LONG) ?
                         hrlp_pkg::LONG_DATA_BYTES : {1'b0, desc_byte[1:0]};
      complete         = (desc_byte[1:0] == 2'd0);
    end else begin
      if (byte_index == 3'd0) begin
        item_value_next = {item_value[15:8], desc_byte};
      end else if (byte_index == 3'd1) begin
        item_value_next = {desc_byte, item_value[7:0]};
      end
      byte_index_next = byte_index + 3'd1;
      bytes_left_next = bytes_left - 3'd1;
      complete        = (bytes_left == 3'd1);
    end
  end

  // Queue a finished item, or the end mark (a cut-off item is dropped)
  assign q_push           = accept && (complete || last_byte);
  assign q_wdata.has_item = complete;
  assign q_wdata.prefix   = item_prefix_next;
  assign q_wdata.value    = item_value_next;
  assign q_wdata.last     = last_byte;

  // Advance assembly; restart on the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      item_prefix <= 8'd0;
      bytes_left  <= 3'd0;
      item_value  <= 16'd0;
      byte_index  <= 3'd0;
    end else if (accept) begin
      if (last_byte) begin
        item_prefix <= 8'd0;
        bytes_left  <= 3'd0;
        item_value  <= 16'd0;
        byte_index  <= 3'd0;
      end else begin
        item_prefix <= item_prefix_next;
        bytes_left  <= bytes_left_next;
        item_value  <= item_value_next;
        byte_index  <= byte_index_next;
      end
    end
  end

endmodule

// ===== design/hrlp_queue.sv =====
module hrlp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  hrlp_pkg::hrlp_entry_t wdata,
  input  logic                  pop,
  output hrlp_pkg::hrlp_entry_t rdata,
  output logic                  full,
  output logic                  empty
);

  hrlp_pkg::hrlp_entry_t slots [hrlp_pkg::QUEUE_DEPTH];

  logic [hrlp_pkg::QUEUE_PW-1:0] wr_ptr;
  logic [hrlp_pkg::QUEUE_PW-1:0] rd_ptr;
  logic [hrlp_pkg::QUEUE_CW-1:0] count;

  assign full  = (count == hrlp_pkg::QUEUE_CW'(hrlp_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + hrlp_pkg::QUEUE_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + hrlp_pkg::QUEUE_PW'(1);
      end
      if (push && !pop) begin
        count <= count + hrlp_pkg::QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - hrlp_pkg::QUEUE_CW'(1);
      end
    end
  end

endmodule

// ===== design/hrlp_exec.sv =====
module hrlp_exec #(
  parameter int USAGE_SLOTS = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  hrlp_pkg::hrlp_entry_t      q_rdata,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output hrlp_pkg::hrlp_layout_t     out_layout,
  output hrlp_pkg::hrlp_exec_stat_t  stat
);

  localparam int TW = $clog2(USAGE_SLOTS + 1);
  localparam int IW = (USAGE_SLOTS > 1) ? $clog2(USAGE_SLOTS) : 1;

  hrlp_pkg::hrlp_exec_state_t state;
  hrlp_pkg::hrlp_exec_state_t state_next;

  logic [7:0]    usage_page;
  logic [15:0]   usage_slots [USAGE_SLOTS];
  logic [TW-1:0] usage_total;
  logic [7:0]    field_count;
  logic [7:0]    field_bits;
  logic [15:0]   bit_offset;
  logic [7:0]    layout_starts [hrlp_pkg::LAYOUT_FIELDS];
  logic [7:0]    layout_lengths [hrlp_pkg::LAYOUT_FIELDS];

  logic [TW-1:0] walk_n;
  logic [TW-1:0] walk_idx;
  logic          walk_last;

  logic [15:0]   prod;
  logic [7:0]    clamp8;
  logic [TW-1:0] clamp_n;
  logic          page_walks;
  logic          walk_start;
  logic [TW-1:0] walk_idx_inc;
  logic          walk_end;
  logic          out_free;
  logic          run;
  logic          step;
  logic          emit;
  logic [15:0]   cur_usage;

  assign prod       = {8'd0, field_count} * {8'd0, field_bits};
  assign clamp8     = (8'(usage_total) < field_count) ? 8'(usage_total) : field_count;
  assign clamp_n    = clamp8[TW-1:0];
  assign page_walks = (usage_page == hrlp_pkg::PAGE_DESKTOP) ||
                      (usage_page == hrlp_pkg::PAGE_CONSUMER);
  assign walk_start = q_rdata.has_item && (q_rdata.prefix == hrlp_pkg::PFX_INPUT) &&
                      page_walks && (clamp_n != '0);
  assign walk_idx_inc = walk_idx + TW'(1);
  assign walk_end     = (walk_idx_inc == walk_n);
  assign out_free     = !out_valid || !out_stall;
  assign cur_usage    = usage_slots[walk_idx[IW-1:0]];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      hrlp_pkg::EX_IDLE: begin
        if (!q_empty) begin
          if (walk_start) begin
            state_next = hrlp_pkg::EX_WALK;
          end else if (q_rdata.last) begin
            state_next = hrlp_pkg::EX_EMIT;
          end
        end
      end
      hrlp_pkg::EX_WALK: begin
        if (walk_end) begin
          state_next = walk_last ? hrlp_pkg::EX_EMIT : hrlp_pkg::EX_IDLE;
        end
      end
      hrlp_pkg::EX_EMIT: begin
        if (out_free) begin
          state_next = hrlp_pkg::EX_IDLE;
        end
      end
      default: state_next = hrlp_pkg::EX_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop = 1'b0;
    run   = 1'b0;
    step  = 1'b0;
    emit  = 1'b0;
    unique case (state)
      hrlp_pkg::EX_IDLE: begin
        q_pop = !q_empty;
        run   = !q_empty && q_rdata.has_item;
      end
      hrlp_pkg::EX_WALK: step = 1'b1;
      hrlp_pkg::EX_EMIT: emit = out_free;
      default: ;
    endcase
  end

  assign stat.pop  = q_pop;
  assign stat.emit = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hrlp_pkg::EX_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Store usages; slots below the count are always freshly written
  always_ff @(posedge clk) begin
    if (run && (q_rdata.prefix == hrlp_pkg::PFX_USAGE ||
                q_rdata.prefix == hrlp_pkg::PFX_USAGE_EXT) &&
        (usage_total < TW'(USAGE_SLOTS))) begin
      usage_slots[usage_total[IW-1:0]] <= q_rdata.value;
    end
  end

  // Walk bookkeeping
  always_ff @(posedge clk) begin
    if (run && walk_start) begin
      walk_n    <= clamp_n;
      walk_idx  <= '0;
      walk_last <= q_rdata.last;
    end else if (step) begin
      walk_idx <= walk_idx_inc;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (emit) begin
      out_layout.button_start  <= layout_starts[hrlp_pkg::L_BUTTON];
      out_layout.button_length <= layout_lengths[hrlp_pkg::L_BUTTON];
      out_layout.x_start       <= layout_starts[hrlp_pkg::L_X];
      out_layout.x_length      <= layout_lengths[hrlp_pkg::L_X];
      out_layout.y_start       <= layout_starts[hrlp_pkg::L_Y];
      out_layout.y_length      <= layout_lengths[hrlp_pkg::L_Y];
      out_layout.wheel_start   <= layout_starts[hrlp_pkg::L_WHEEL];
      out_layout.wheel_length  <= layout_lengths[hrlp_pkg::L_WHEEL];
      out_layout.pan_start     <= layout_starts[hrlp_pkg::L_PAN];
      out_layout.pan_length    <= layout_lengths[hrlp_pkg::L_PAN];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Parser state: run items, walk usages, clear after emitting
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      usage_page  <= 8'd0;
      usage_total <= '0;
      field_count <= hrlp_pkg::REPORT_COUNT_RESET;
      field_bits  <= 8'd0;
      bit_offset  <= 16'd0;
      for (int k = 0; k < hrlp_pkg::LAYOUT_FIELDS; k++) begin
        layout_starts[k]  <= 8'd0;
        layout_lengths[k] <= 8'd0;
      end
    end else if (run) begin
      unique case (q_rdata.prefix) inside
        hrlp_pkg::PFX_USAGE_PAGE: usage_page <= q_rdata.value[7:0];
        hrlp_pkg::PFX_USAGE, hrlp_pkg::PFX_USAGE_EXT: begin
          if (usage_total < TW'(USAGE_SLOTS)) begin
            usage_total <= usage_total + TW'(1);
          end
        end
        hrlp_pkg::PFX_REPORT_COUNT: field_count <= q_rdata.value[7:0];
        hrlp_pkg::PFX_REPORT_SIZE:  field_bits  <= q_rdata.value[7:0];
        hrlp_pkg::PFX_INPUT: begin
          if (usage_page == hrlp_pkg::PAGE_BUTTON) begin
            layout_starts[hrlp_pkg::L_BUTTON]  <= bit_offset[7:0];
            layout_lengths[hrlp_pkg::L_BUTTON] <= prod[7:0];
            bit_offset <= bit_offset + {8'd0, prod[7:0]};
          end else if (!page_walks) begin
            bit_offset <= bit_offset + prod;
          end
          // A walk keeps page and count until its last step
          if (!walk_start) begin
            usage_page  <= 8'd0;
            usage_total <= '0;
          end
        end
        hrlp_pkg::PFX_OUTPUT: usage_total <= '0;
        default: ;
      endcase
    end else if (step) begin
      if (usage_page == hrlp_pkg::PAGE_DESKTOP) begin
        if (cur_usage == hrlp_pkg::USAGE_X) begin
          layout_starts[hrlp_pkg::L_X]  <= bit_offset[7:0];
          layout_lengths[hrlp_pkg::L_X] <= field_bits;
        end else if (cur_usage == hrlp_pkg::USAGE_Y) begin
          layout_starts[hrlp_pkg::L_Y]  <= bit_offset[7:0];
          layout_lengths[hrlp_pkg::L_Y] <= field_bits;
        end else if (cur_usage == hrlp_pkg::USAGE_WHEEL) begin
          layout_starts[hrlp_pkg::L_WHEEL]  <= bit_offset[7:0];
          layout_lengths[hrlp_pkg::L_WHEEL] <= field_bits;
        end
      end else if (cur_usage == hrlp_pkg::USAGE_AC_PAN) begin
        layout_starts[hrlp_pkg::L_PAN]  <= bit_offset[7:0];
        layout_lengths[hrlp_pkg::L_PAN] <= field_bits;
      end
      bit_offset <= bit_offset + {8'd0, field_bits};
      if (walk_end) begin
        usage_page  <= 8'd0;
        usage_total <= '0;
      end
    end
  end

endmodule
